/* rtl/apst_pkg.sv */
// Shared types and constants for the ARM prologue stack-frame tracker.
// No dependencies; every rtl file refers to it by scoped names.
package apst_pkg;

  localparam logic [3:0] COND_ALWAYS = 4'hE;
  localparam logic [3:0] REG_SP      = 4'd13;
  localparam logic [3:0] REG_LR      = 4'd14;
  localparam logic [3:0] REG_PC      = 4'd15;

  localparam logic [2:0] TYPE_DP_IMM = 3'b001;
  localparam logic [2:0] TYPE_LS_IMM = 3'b010;
  localparam logic [2:0] TYPE_BLOCK  = 3'b100;

  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd4;

  localparam int unsigned BIT_P = 24;
  localparam int unsigned BIT_U = 23;
  localparam int unsigned BIT_W = 21;
  localparam int unsigned BIT_L = 20;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LR_ADD_W = 6;

  // Classified instruction: everything the execute side needs, state free.
  typedef struct packed {
    logic                new_frame;
    logic [WORD_W-1:0]   frame_delta;
    logic                lr_en;
    logic [LR_ADD_W-1:0] lr_add;
  } dec_t;

endpackage

/* rtl/apst_front.sv */
// Front end: classifies one ARM instruction word into a frame delta and lr record.
// Depends on apst_pkg.
module apst_front (
  input  logic [31:0]   instruction,
  input  logic          new_frame,
  output apst_pkg::dec_t dec
);

  logic [3:0]  cond;
  logic [2:0]  itype;
  logic [3:0]  opc;
  logic [3:0]  rn;
  logic [3:0]  rd;
  logic [4:0]  rot_amt;
  logic [63:0] rot_dbl;
  logic [31:0] rot_imm;
  logic [31:0] ls_off;
  logic [15:0] reg_list;
  logic [4:0]  n_regs;
  logic [3:0]  n_below;
  logic [31:0] blk_bytes;

  assign cond     = instruction[31:28];
  assign itype    = instruction[27:25];
  assign opc      = instruction[24:21];
  assign rn       = instruction[19:16];
  assign rd       = instruction[15:12];
  assign reg_list = instruction[15:0];

  // Rotate right by twice the rotate field.
  assign rot_amt = {instruction[11:8], 1'b0};
  assign rot_dbl = {24'd0, instruction[7:0], 24'd0, instruction[7:0]} >> rot_amt;
  assign rot_imm = rot_dbl[31:0];

  assign ls_off = {20'd0, instruction[11:0]};

  always_comb begin
    n_regs  = '0;
    n_below = '0;
    for (int i = 0; i < 16; i++) begin
      n_regs = n_regs + 5'(reg_list[i]);
      if (i < 14) begin
        n_below = n_below + 4'(reg_list[i]);
      end
    end
  end

  assign blk_bytes = {25'd0, n_regs, 2'b00};

  always_comb begin
    dec.new_frame   = new_frame;
    dec.frame_delta = '0;
    dec.lr_en       = 1'b0;
    dec.lr_add      = '0;
    if (cond == apst_pkg::COND_ALWAYS) begin
      unique case (itype)
        apst_pkg::TYPE_DP_IMM: begin
          if (rd == apst_pkg::REG_SP && rn == apst_pkg::REG_SP) begin
            if (opc == apst_pkg::OP_SUB) begin
              dec.frame_delta = rot_imm;
            end else if (opc == apst_pkg::OP_ADD) begin
              dec.frame_delta = 32'd0 - rot_imm;
            end
          end
        end
        apst_pkg::TYPE_LS_IMM: begin
          if (rn == apst_pkg::REG_SP && rd != apst_pkg::REG_PC &&
              !(instruction[apst_pkg::BIT_P] && !instruction[apst_pkg::BIT_W])) begin
            dec.frame_delta = instruction[apst_pkg::BIT_U] ? (32'd0 - ls_off) : ls_off;
            if (instruction[apst_pkg::BIT_P] && !instruction[apst_pkg::BIT_L] &&
                rd == apst_pkg::REG_LR) begin
              dec.lr_en = 1'b1;
            end
          end
        end
        apst_pkg::TYPE_BLOCK: begin
          if (rn == apst_pkg::REG_SP && !reg_list[15] && n_regs != 5'd0) begin
            if (instruction[apst_pkg::BIT_U]) begin
              // Increment after / before: frame shrinks.
              if (instruction[apst_pkg::BIT_W]) begin
                dec.frame_delta = 32'd0 - blk_bytes;
              end
            end else begin
              if (instruction[apst_pkg::BIT_W]) begin
                dec.frame_delta = blk_bytes;
              end
              // Decrement before: store of lr records its slot.
              if (instruction[apst_pkg::BIT_P] && !instruction[apst_pkg::BIT_L] &&
                  reg_list[14]) begin
                dec.lr_en  = 1'b1;
                dec.lr_add = {n_below, 2'b00};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/apst_queue.sv */
// Short FIFO of classified words between the front end and the execute side.
// Depends on apst_pkg for the entry type.
module apst_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  apst_pkg::dec_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output apst_pkg::dec_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  apst_pkg::dec_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_en && !full;
  assign pop      = rd_en && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

/* rtl/apst_back.sv */
// Execute side: applies classified words to the frame state and holds the result word.
// Depends on apst_pkg.
module apst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  apst_pkg::dec_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_lr_saved,
  output logic signed [31:0] out_frame_size,
  output logic signed [31:0] out_lr_slot_offset
);

  logic [31:0] frame_bytes_r, frame_bytes_nxt;
  logic [31:0] lr_offset_r, lr_offset_nxt;
  logic [31:0] base;
  logic        out_valid_r, out_valid_nxt;
  logic        lr_saved_r;
  logic [31:0] frame_out_r;
  logic [31:0] lr_out_r;

  // Take a new word when the result register is empty or being drained.
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  assign base            = q_data.new_frame ? 32'd0 : frame_bytes_r;
  assign frame_bytes_nxt = base + q_data.frame_delta;

  always_comb begin
    if (q_data.lr_en) begin
      lr_offset_nxt = base + {26'd0, q_data.lr_add};
    end else if (q_data.new_frame) begin
      lr_offset_nxt = '0;
    end else begin
      lr_offset_nxt = lr_offset_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= '0;
      lr_offset_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        frame_bytes_r <= frame_bytes_nxt;
        lr_offset_r   <= lr_offset_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lr_saved_r  <= q_data.lr_en;
      frame_out_r <= frame_bytes_nxt;
      lr_out_r    <= lr_offset_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lr_saved       = lr_saved_r;
  assign out_frame_size     = frame_out_r;
  assign out_lr_slot_offset = lr_out_r;

`ifndef NO_ASSERTIONS
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> ($stable(frame_bytes_r) && $stable(lr_offset_r)))
    else $error("frame state changed without a word");

  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && frame_out_r == frame_bytes_r && lr_out_r == lr_offset_r))
    else $error("result word does not match frame state");
`endif

endmodule

/* rtl/arm_prologue_stack_frame_tracker.sv */
// An accepted word is written into the queue, then into the result register on out_*.
// Throughput: one instruction per cycle while out_stall is low; the queue absorbs
// QUEUE_DEPTH words of out_stall. The frame update (one 32-bit add) sets the rate.
// Reset (rst_n low, synchronous): frame size and lr offset go to zero, queue empties,
// out_valid drops. No clearing pass; the block takes words straight after reset.
module arm_prologue_stack_frame_tracker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_instruction,
  input  logic               in_new_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_lr_saved,
  output logic signed [31:0] out_frame_size,
  output logic signed [31:0] out_lr_slot_offset
);

  // Front end: classify the word; nothing here depends on the frame state,
  // so decode runs ahead of execution freely.
  apst_pkg::dec_t dec;
  apst_pkg::dec_t q_data;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           in_accept;

  apst_front u_front (
    .instruction (in_instruction),
    .new_frame   (in_new_frame),
    .dec         (dec)
  );

  // Stall the input only when the queue is full; a held result word at the
  // output does not block acceptance until the queue has filled behind it.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  apst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_accept),
    .wr_data  (dec),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_data)
  );

  // Back end: advance frame size and lr offset, then hold the result word
  // in its output register until the far side takes it.
  apst_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_lr_saved       (out_lr_saved),
    .out_frame_size     (out_frame_size),
    .out_lr_slot_offset (out_lr_slot_offset)
  );

endmodule
